>>> rtl/fcbr_pkg.sv
package fcbr_pkg;

  localparam int unsigned FILL_W    = 23;
  localparam int unsigned CHUNK_W   = 20;
  localparam int unsigned IDX_OUT_W = 4;
  localparam int unsigned CFG_W     = 23;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned DEFAULT_BUFFER_COUNT = 4;

  localparam logic [FILL_W-1:0]  FILL_MAX              = 23'h7FFFFF;
  localparam logic [FILL_W-1:0]  FRAME_BYTES_RESET     = 23'(1280 * 960);
  localparam logic [CHUNK_W-1:0] CHUNK_BYTES_RESET     = 20'h4C000;
  localparam logic [FILL_W-1:0]  BUFFER_CAPACITY_RESET = 23'(1280 * 960);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BYTES     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BYTES     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_CAPACITY = 2'd2;

  localparam logic CMD_CHUNK   = 1'b0;
  localparam logic CMD_CAPTURE = 1'b1;

endpackage

>>> rtl/frame_chunk_buffer_rotator_core.sv
// Channel  | Handshake               | Payload
// ---------+-------------------------+-----------------------------------------------
// in       | in_valid / in_ready     | command, chunk_ok, chunk_length
// out      | out_valid / out_ready   | buffer_index, write_offset, copy_length,
//          |                         | frame_done, frame_bad, next_capture_index,
//          |                         | frame_found, frame_length
// cfg      | cfg_write_en            | cfg_index, cfg_data
//
// Each item passes the buffer search and fill-count memory read, then the
// read-modify-write, then, for a completed frame with a next capture buffer, a
// second write to clear that buffer. A new item is accepted only when idle.
// The single write port of the fill-count memory is why the clear takes its own step.
// Reset is synchronous, in_ready stays low during it; fill counts read as zero
// through per-entry valid bits. A finished result waits in the output register and
// the block stalls in the execute step only while that register is still full.
module frame_chunk_buffer_rotator_core #(
  parameter int unsigned BUFFER_COUNT = fcbr_pkg::DEFAULT_BUFFER_COUNT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [fcbr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcbr_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             command,
  input  logic                             chunk_ok,
  input  logic [fcbr_pkg::CHUNK_W-1:0]     chunk_length,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fcbr_pkg::IDX_OUT_W-1:0]   buffer_index,
  output logic [fcbr_pkg::FILL_W-1:0]      write_offset,
  output logic [fcbr_pkg::CHUNK_W-1:0]     copy_length,
  output logic                             frame_done,
  output logic                             frame_bad,
  output logic [fcbr_pkg::IDX_OUT_W-1:0]   next_capture_index,
  output logic                             frame_found,
  output logic [fcbr_pkg::FILL_W-1:0]      frame_length
);
  import fcbr_pkg::*;

  localparam int unsigned IDX_W = $clog2(BUFFER_COUNT);

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FIND  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_CLEAR = 4'b1000
  } state_t;

  state_t state;

  logic [FILL_W-1:0]  frame_bytes;
  logic [CHUNK_W-1:0] chunk_bytes;
  logic [FILL_W-1:0]  buffer_capacity;

  logic [BUFFER_COUNT-1:0] active_flag;
  logic [BUFFER_COUNT-1:0] filled_flag;
  idx_t capture_index;
  idx_t export_index;

  logic               cmd;
  logic               ok;
  logic [CHUNK_W-1:0] len;
  idx_t               srch_idx;
  logic               srch_found;

  logic [FILL_W-1:0]       fill_mem [BUFFER_COUNT];
  logic [BUFFER_COUNT-1:0] fill_vld;
  logic [FILL_W-1:0]       rd_data;
  logic                    rd_vld;
  idx_t                    rd_idx;
  logic                    wr_en;
  logic [FILL_W-1:0]       wr_data;

  idx_t fwd_idx;
  logic fwd_found;
  idx_t bwd_idx;
  logic bwd_found;

  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] room;
  logic [FILL_W-1:0] len_ext;
  logic [FILL_W-1:0] copy_full;
  logic [FILL_W:0]   sum_raw;
  logic [FILL_W-1:0] sum_sat;
  logic              reach;
  logic              short_chunk;
  logic              done;
  logic              bad;
  logic              out_free;
  logic              advance;

  function automatic idx_t wrap_add(idx_t base, int unsigned step);
    logic [IDX_W:0] s;
    s = {1'b0, base} + (IDX_W+1)'(step);
    if (s >= (IDX_W+1)'(BUFFER_COUNT)) begin
      s = s - (IDX_W+1)'(BUFFER_COUNT);
    end
    return s[IDX_W-1:0];
  endfunction

  assign in_ready = (state == S_IDLE) && !rst;
  assign out_free = !out_valid || out_ready;

  // next active buffer after capture, and newest active filled buffer before it
  always_comb begin
    idx_t cand;
    fwd_found = 1'b0;
    fwd_idx   = capture_index;
    bwd_found = 1'b0;
    bwd_idx   = capture_index;
    for (int i = BUFFER_COUNT - 1; i >= 0; i--) begin
      cand = wrap_add(capture_index, 32'(i) + 1);
      if (active_flag[cand]) begin
        fwd_found = 1'b1;
        fwd_idx   = cand;
      end
      cand = wrap_add(capture_index, BUFFER_COUNT - 1 - 32'(i));
      if (active_flag[cand] && filled_flag[cand]) begin
        bwd_found = 1'b1;
        bwd_idx   = cand;
      end
    end
  end

  assign rd_idx = (cmd == CMD_CHUNK) ? capture_index : (bwd_found ? bwd_idx : export_index);

  always_comb begin
    fill        = rd_vld ? rd_data : '0;
    room        = (buffer_capacity > fill) ? (buffer_capacity - fill) : '0;
    len_ext     = FILL_W'(len);
    copy_full   = (len_ext < room) ? len_ext : room;
    sum_raw     = {1'b0, fill} + (FILL_W+1)'(len);
    sum_sat     = sum_raw[FILL_W] ? FILL_MAX : sum_raw[FILL_W-1:0];
    reach       = (sum_sat >= frame_bytes);
    short_chunk = (len < chunk_bytes);
    done        = ok && short_chunk && reach;
    bad         = ok && (short_chunk ? !reach : reach);
  end

  assign advance = (state == S_EXEC) && out_free;

  always_comb begin
    wr_en   = 1'b0;
    wr_data = '0;
    if (advance && cmd == CMD_CHUNK && ok) begin
      wr_en   = 1'b1;
      wr_data = bad ? '0 : sum_sat;
    end else if (state == S_CLEAR) begin
      wr_en   = 1'b1;
    end
  end

  // fill-count memory: one write port at the capture buffer, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      fill_mem[capture_index] <= wr_data;
    end
    if (state == S_FIND) begin
      rd_data <= fill_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_vld <= '0;
      rd_vld   <= 1'b0;
    end else begin
      if (wr_en) begin
        fill_vld[capture_index] <= 1'b1;
      end
      if (state == S_FIND) begin
        rd_vld <= fill_vld[rd_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bytes     <= FRAME_BYTES_RESET;
      chunk_bytes     <= CHUNK_BYTES_RESET;
      buffer_capacity <= BUFFER_CAPACITY_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_FRAME_BYTES:     frame_bytes     <= cfg_data[FILL_W-1:0];
        REG_CHUNK_BYTES:     chunk_bytes     <= cfg_data[CHUNK_W-1:0];
        REG_BUFFER_CAPACITY: buffer_capacity <= cfg_data[FILL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= command;
      ok  <= chunk_ok;
      len <= chunk_length;
    end
    if (state == S_FIND) begin
      srch_idx   <= fwd_idx;
      srch_found <= (cmd == CMD_CHUNK) ? fwd_found : bwd_found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      active_flag   <= '1;
      filled_flag   <= '0;
      capture_index <= '0;
      export_index  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_FIND;
          end
        end
        S_FIND: begin
          if (cmd == CMD_CAPTURE) begin
            if (bwd_found) begin
              export_index         <= bwd_idx;
              active_flag[bwd_idx] <= 1'b0;
            end
            filled_flag[export_index] <= 1'b0;
            active_flag[export_index] <= 1'b1;
          end
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) begin
            state <= S_IDLE;
            if (cmd == CMD_CHUNK && done) begin
              if (srch_found) begin
                capture_index         <= srch_idx;
                filled_flag[srch_idx] <= 1'b0;
                state                 <= S_CLEAR;
              end
              filled_flag[capture_index] <= 1'b1;
            end
          end
        end
        S_CLEAR: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (cmd == CMD_CHUNK) begin
        buffer_index       <= IDX_OUT_W'(capture_index);
        write_offset       <= fill;
        copy_length        <= ok ? copy_full[CHUNK_W-1:0] : '0;
        frame_done         <= done;
        frame_bad          <= bad;
        next_capture_index <= (done && srch_found) ? IDX_OUT_W'(srch_idx)
                                                   : IDX_OUT_W'(capture_index);
        frame_found        <= 1'b0;
        frame_length       <= '0;
      end else begin
        buffer_index       <= IDX_OUT_W'(export_index);
        write_offset       <= '0;
        copy_length        <= '0;
        frame_done         <= 1'b0;
        frame_bad          <= 1'b0;
        next_capture_index <= IDX_OUT_W'(capture_index);
        frame_found        <= srch_found;
        frame_length       <= fill;
      end
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in progress");

  a_done_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(frame_done && frame_bad))
    else $error("frame reported both done and corrupt");

  a_capture_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_found |-> write_offset == '0 && copy_length == '0 && !frame_done)
    else $error("capture result carries chunk fields");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, capture_index} < (IDX_W+1)'(BUFFER_COUNT)
    && {1'b0, export_index} < (IDX_W+1)'(BUFFER_COUNT))
    else $error("buffer index out of range");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == S_EXEC || state == S_CLEAR)
    else $error("fill memory written outside execute or clear");

endmodule

>>> test/fcbr_checker.sv
module fcbr_checker #(
  parameter int unsigned BUFFER_COUNT = fcbr_pkg::DEFAULT_BUFFER_COUNT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [fcbr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcbr_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             command,
  input  logic                             chunk_ok,
  input  logic [fcbr_pkg::CHUNK_W-1:0]     chunk_length,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [fcbr_pkg::IDX_OUT_W-1:0]   buffer_index,
  input  logic [fcbr_pkg::FILL_W-1:0]      write_offset,
  input  logic [fcbr_pkg::CHUNK_W-1:0]     copy_length,
  input  logic                             frame_done,
  input  logic                             frame_bad,
  input  logic [fcbr_pkg::IDX_OUT_W-1:0]   next_capture_index,
  input  logic                             frame_found,
  input  logic [fcbr_pkg::FILL_W-1:0]      frame_length,
  output int                               fail_count,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import fcbr_pkg::*;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] buffer_index;
    logic [FILL_W-1:0]    write_offset;
    logic [CHUNK_W-1:0]   copy_length;
    logic                 frame_done;
    logic                 frame_bad;
    logic [IDX_OUT_W-1:0] next_capture_index;
    logic                 frame_found;
    logic [FILL_W-1:0]    frame_length;
  } placement_t;

  placement_t placements[$];
  placement_t head;

  logic [FILL_W-1:0]  fill_cnt [BUFFER_COUNT];
  logic               active   [BUFFER_COUNT];
  logic               filled   [BUFFER_COUNT];
  int unsigned        cap_idx;
  int unsigned        exp_idx;

  logic [FILL_W-1:0]  frame_sz;
  logic [CHUNK_W-1:0] chunk_sz;
  logic [FILL_W-1:0]  cap_sz;

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("checker: %s mismatch, got 0x%0h want 0x%0h", what, got, want);
    fail_count++;
  endtask

  function automatic placement_t place_or_export(logic cmd, logic ok,
                                                 logic [CHUNK_W-1:0] len);
    placement_t  r;
    int unsigned cur;
    int unsigned old;
    int unsigned fill;
    int unsigned room;
    int unsigned copy;
    int unsigned sum;
    int unsigned idx;
    int unsigned i;
    r = '0;
    cur = cap_idx;
    if (cmd == CMD_CHUNK) begin
      fill = fill_cnt[cur];
      room = (cap_sz > fill) ? cap_sz - fill : 0;
      copy = (len < room) ? len : room;
      r.buffer_index = IDX_OUT_W'(cur);
      r.write_offset = FILL_W'(fill);
      if (ok) begin
        sum = fill + len;
        if (sum > FILL_MAX) sum = FILL_MAX;
        fill_cnt[cur] = FILL_W'(sum);
        r.copy_length = CHUNK_W'(copy);
        if (len < chunk_sz) begin
          if (sum >= frame_sz) r.frame_done = 1'b1;
          else r.frame_bad = 1'b1;
        end else if (sum >= frame_sz) begin
          r.frame_bad = 1'b1;
        end
        if (r.frame_bad) begin
          fill_cnt[cur] = '0;
        end else if (r.frame_done) begin
          for (i = 0; i < BUFFER_COUNT; i++) begin
            idx = (cur + i + 1) % BUFFER_COUNT;
            if (active[idx]) begin
              cap_idx = idx;
              filled[idx] = 1'b0;
              fill_cnt[idx] = '0;
              break;
            end
          end
          filled[cur] = 1'b1;
        end
      end
      r.next_capture_index = IDX_OUT_W'(cap_idx);
    end else begin
      old = exp_idx;
      for (i = 0; i < BUFFER_COUNT; i++) begin
        idx = (cur + BUFFER_COUNT - i - 1) % BUFFER_COUNT;
        if (active[idx] && filled[idx]) begin
          r.frame_found = 1'b1;
          exp_idx = idx;
          active[idx] = 1'b0;
          break;
        end
      end
      filled[old] = 1'b0;
      active[old] = 1'b1;
      r.buffer_index = IDX_OUT_W'(exp_idx);
      r.next_capture_index = IDX_OUT_W'(cur);
      r.frame_length = fill_cnt[exp_idx];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (fill_cnt[k]) begin
        fill_cnt[k] = '0;
        active[k] = 1'b1;
        filled[k] = 1'b0;
      end
      cap_idx = 0;
      exp_idx = 0;
      frame_sz = FRAME_BYTES_RESET;
      chunk_sz = CHUNK_BYTES_RESET;
      cap_sz = BUFFER_CAPACITY_RESET;
      placements.delete();
      pending = 0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_FRAME_BYTES:     frame_sz = cfg_data;
          REG_CHUNK_BYTES:     chunk_sz = cfg_data[CHUNK_W-1:0];
          REG_BUFFER_CAPACITY: cap_sz = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        placements.push_back(place_or_export(command, chunk_ok, chunk_length));
      if (out_valid && out_ready) begin
        if (placements.size() == 0) begin
          report("unexpected transfer, buffer_index", buffer_index, 0);
        end else begin
          head = placements.pop_front();
          if (buffer_index !== head.buffer_index)
            report("buffer_index", buffer_index, head.buffer_index);
          if (write_offset !== head.write_offset)
            report("write_offset", write_offset, head.write_offset);
          if (copy_length !== head.copy_length)
            report("copy_length", copy_length, head.copy_length);
          if (frame_done !== head.frame_done)
            report("frame_done", frame_done, head.frame_done);
          if (frame_bad !== head.frame_bad)
            report("frame_bad", frame_bad, head.frame_bad);
          if (next_capture_index !== head.next_capture_index)
            report("next_capture_index", next_capture_index, head.next_capture_index);
          if (frame_found !== head.frame_found)
            report("frame_found", frame_found, head.frame_found);
          if (frame_length !== head.frame_length)
            report("frame_length", frame_length, head.frame_length);
        end
      end
      pending = placements.size();
    end
  end

endmodule

>>> test/frame_chunk_buffer_rotator_core_tb.sv
module frame_chunk_buffer_rotator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcbr_pkg::*;

  localparam int unsigned BUFFERS     = 4;
  localparam int          IDLE_LIMIT  = 3000;
  localparam int          HOLD_CYCLES = 300;
  localparam int unsigned LEN_MAX     = 20'hFFFFF;
  localparam int unsigned CFG_MAX     = 4915200;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 command = CMD_CHUNK;
  logic                 chunk_ok = 1'b0;
  logic [CHUNK_W-1:0]   chunk_length = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [IDX_OUT_W-1:0] buffer_index;
  logic [FILL_W-1:0]    write_offset;
  logic [CHUNK_W-1:0]   copy_length;
  logic                 frame_done;
  logic                 frame_bad;
  logic [IDX_OUT_W-1:0] next_capture_index;
  logic                 frame_found;
  logic [FILL_W-1:0]    frame_length;

  int fail_count;
  int pending;

  bit          hold_req = 1'b0;
  int          sent = 0;
  int          burst_left = 0;
  int unsigned frame_sz = FRAME_BYTES_RESET;
  int unsigned chunk_sz = CHUNK_BYTES_RESET;

  always #4 clk = ~clk;

  frame_chunk_buffer_rotator_core #(.BUFFER_COUNT(BUFFERS)) u_dut (
    .clk, .rst, .cfg_write_en, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .command, .chunk_ok, .chunk_length,
    .out_valid, .out_ready, .buffer_index, .write_offset, .copy_length,
    .frame_done, .frame_bad, .next_capture_index, .frame_found, .frame_length
  );

  fcbr_checker #(.BUFFER_COUNT(BUFFERS)) u_check (
    .clk, .rst, .cfg_write_en, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .command, .chunk_ok, .chunk_length,
    .out_valid, .out_ready, .buffer_index, .write_offset, .copy_length,
    .frame_done, .frame_bad, .next_capture_index, .frame_found, .frame_length,
    .fail_count, .pending
  );

  task automatic send_item(logic cmd, logic ok, logic [CHUNK_W-1:0] len);
    @(negedge clk);
    in_valid <= 1'b1;
    command <= cmd;
    chunk_ok <= ok;
    chunk_length <= len;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic gap(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic offer(logic cmd, logic ok, logic [CHUNK_W-1:0] len);
    send_item(cmd, ok, len);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 4) != 0) gap($urandom_range(1, 7));
    end
  endtask

  task automatic drain();
    gap(1);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_config(int unsigned f, int unsigned c, int unsigned b);
    drain();
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= REG_FRAME_BYTES;
    cfg_data <= CFG_W'(f);
    @(negedge clk);
    cfg_index <= REG_CHUNK_BYTES;
    cfg_data <= CFG_W'(c);
    @(negedge clk);
    cfg_index <= REG_BUFFER_CAPACITY;
    cfg_data <= CFG_W'(b);
    @(negedge clk);
    cfg_write_en <= 1'b0;
    frame_sz = f;
    chunk_sz = c;
  endtask

  task automatic pick_config(bit big, output int unsigned f, output int unsigned c,
                             output int unsigned b);
    if (big) begin
      f = $urandom_range(1, CFG_MAX);
      c = $urandom_range(f / 6 + 1, LEN_MAX);
    end else begin
      f = $urandom_range(1, 4000);
      c = $urandom_range(f / 8 + 1, f + 20);
    end
    case ($urandom_range(0, 2))
      0: b = f;
      1: b = $urandom_range(1, f);
      default: b = f + $urandom_range(0, 500);
    endcase
    if (b > CFG_MAX) b = CFG_MAX;
  endtask

  // up to 12 full chunks below the frame size, then a short closing chunk
  task automatic send_frame();
    int unsigned n_full;
    int unsigned rem;
    int unsigned len;
    int unsigned top;
    int unsigned k;
    n_full = (frame_sz - 1) / chunk_sz;
    if (n_full > 12) n_full = 12;
    for (k = 0; k < n_full; k++) begin
      if ($urandom_range(0, 9) == 0)
        offer(CMD_CAPTURE, 1'($urandom_range(0, 1)), CHUNK_W'($urandom));
      if ($urandom_range(0, 19) == 0)
        offer(CMD_CHUNK, 1'b0, CHUNK_W'($urandom));
      len = chunk_sz;
      if ($urandom_range(0, 9) == 0) begin
        top = chunk_sz + chunk_sz / 4 + 1;
        if (top > LEN_MAX) top = LEN_MAX;
        len = $urandom_range(chunk_sz, top);
      end
      offer(CMD_CHUNK, 1'b1, CHUNK_W'(len));
    end
    rem = frame_sz - n_full * chunk_sz;
    if (rem < chunk_sz && $urandom_range(0, 9) != 0) len = $urandom_range(rem, chunk_sz - 1);
    else len = $urandom_range(0, chunk_sz - 1);
    offer(CMD_CHUNK, 1'b1, CHUNK_W'(len));
  endtask

  task automatic random_items(int count);
    int target;
    int unsigned r;
    target = sent + count;
    while (sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 55) send_frame();
      else if (r < 75) offer(CMD_CAPTURE, 1'($urandom_range(0, 1)), CHUNK_W'($urandom));
      else if (r < 88) offer(CMD_CHUNK, 1'b0, CHUNK_W'($urandom));
      else offer(CMD_CHUNK, 1'b1, CHUNK_W'($urandom >> $urandom_range(0, 19)));
    end
  endtask

  initial begin : receiver
    int mode;
    int seg;
    int cyc;
    cyc = 0;
    forever begin
      mode = $urandom_range(0, 3);
      seg = $urandom_range(10, 150);
      repeat (seg) begin
        @(negedge clk);
        cyc++;
        if (hold_req) begin
          hold_req = 1'b0;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES - 1) @(negedge clk);
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (cyc % 3 != 0);
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int unsigned f;
    int unsigned c;
    int unsigned b;
    int p;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // default registers: failed chunk, empty capture, clipped closing chunk
    send_item(CMD_CHUNK, 1'b0, 20'hFFFFF);
    send_item(CMD_CAPTURE, 1'b0, 20'h00000);
    send_item(CMD_CHUNK, 1'b1, 20'h00000);
    repeat (3) send_item(CMD_CHUNK, 1'b1, CHUNK_BYTES_RESET);
    send_item(CMD_CHUNK, 1'b0, 20'h00005);
    send_item(CMD_CHUNK, 1'b1, 20'd300000);
    send_item(CMD_CAPTURE, 1'b1, 20'hFFFFF);
    send_item(CMD_CHUNK, 1'b1, 20'hFFFFF);
    send_item(CMD_CHUNK, 1'b1, 20'hFFFFF);
    send_item(CMD_CAPTURE, 1'b0, 20'h00000);

    set_config(1, 1, 1);
    send_item(CMD_CHUNK, 1'b1, 20'h00000);
    send_item(CMD_CHUNK, 1'b1, 20'h00001);
    send_item(CMD_CAPTURE, 1'b1, 20'h00000);

    // capacity below the frame: clipped, then overfull
    set_config(1000, 300, 100);
    repeat (3) send_item(CMD_CHUNK, 1'b1, 20'd300);
    send_item(CMD_CHUNK, 1'b1, 20'd200);
    send_item(CMD_CAPTURE, 1'b0, 20'h00000);
    send_item(CMD_CAPTURE, 1'b0, 20'h00000);

    set_config(CFG_MAX, LEN_MAX, CFG_MAX);
    repeat (4) send_item(CMD_CHUNK, 1'b1, 20'hFFFFF);
    send_item(CMD_CHUNK, 1'b1, 20'hFFFFE);

    for (p = 0; p < 9; p++) begin
      case (p)
        1: set_config(1, 1, 1);
        5: set_config(CFG_MAX, LEN_MAX, CFG_MAX);
        4, 8: begin
          pick_config(1'b1, f, c, b);
          set_config(f, c, b);
        end
        default: begin
          pick_config(1'b0, f, c, b);
          set_config(f, c, b);
        end
      endcase
      if (p == 2) begin
        hold_req = 1'b1;
        repeat (24) send_item(1'($urandom_range(0, 1)), 1'b1,
                              CHUNK_W'($urandom_range(0, chunk_sz)));
      end
      if (p == 3) begin
        random_items(50);
        drain();
        random_items(60);
      end else if (p == 1 || p == 5) begin
        random_items(40);
      end else begin
        random_items(100);
      end
    end

    gap(1);
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
